// ===== rtl/core/rob_pkg.sv =====
// ============================================================================
// rob_pkg
// Shared types and codes for the reorder buffer: commands, error codes,
// channel payloads and the controller/datapath link.
// ============================================================================
package rob_pkg;

   typedef enum logic [2:0] {
      CMD_ALLOC    = 3'd0,
      CMD_WB       = 3'd1,
      CMD_SET_ACT  = 3'd2,
      CMD_SET_PRED = 3'd3,
      CMD_COMMIT   = 3'd4,
      CMD_FLUSH    = 3'd5,
      CMD_QUERY    = 3'd6
   } cmd_type;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  tag;
      logic [7:0]  op_kind;
      logic [4:0]  dest_index;
      logic [31:0] instr_pc;
      logic [31:0] result_value;
      logic        branch_taken;
      logic [31:0] branch_target;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  slot_out;
      logic [4:0]  occupancy;
      logic        ready_out;
      logic [31:0] value_out;
      logic [7:0]  head_op;
      logic [4:0]  head_dest;
      logic [31:0] head_pc;
      logic        head_bp_taken;
      logic [31:0] head_bp_target;
      logic        head_act_taken;
      logic [31:0] head_act_target;
      logic [1:0]  error;
   } rsp_payload_type;

   // one buffer entry as held in the entry memory
   typedef struct packed {
      logic        act_taken;
      logic        bp_taken;
      logic        ready;
      logic        busy;
      logic [7:0]  op;
      logic [4:0]  dest;
      logic [31:0] value;
      logic [31:0] pc;
      logic [31:0] bp_target;
      logic [31:0] act_target;
   } entry_type;

   typedef struct packed {
      logic capture;   // latch request, read head and tag entries
      logic execute;   // apply the command, load the response register
   } ctrl_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dp_status_type;

endpackage

// ===== rtl/core/rob_req_if.sv =====
// ============================================================================
// rob_req_if
// Request channel of the reorder buffer: valid/ready plus command payload.
// ============================================================================
interface rob_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [3:0]  tag;
   logic [7:0]  op_kind;
   logic [4:0]  dest_index;
   logic [31:0] instr_pc;
   logic [31:0] result_value;
   logic        branch_taken;
   logic [31:0] branch_target;

   modport source (
      output valid, cmd, tag, op_kind, dest_index, instr_pc, result_value,
             branch_taken, branch_target,
      input  ready
   );

   modport sink (
      input  valid, cmd, tag, op_kind, dest_index, instr_pc, result_value,
             branch_taken, branch_target,
      output ready
   );
endinterface

// ===== rtl/core/rob_rsp_if.sv =====
// ============================================================================
// rob_rsp_if
// Response channel of the reorder buffer: valid/ready plus result payload.
// ============================================================================
interface rob_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  slot_out;
   logic [4:0]  occupancy;
   logic        ready_out;
   logic [31:0] value_out;
   logic [7:0]  head_op;
   logic [4:0]  head_dest;
   logic [31:0] head_pc;
   logic        head_bp_taken;
   logic [31:0] head_bp_target;
   logic        head_act_taken;
   logic [31:0] head_act_target;
   logic [1:0]  error;

   modport source (
      output valid, slot_out, occupancy, ready_out, value_out, head_op, head_dest,
             head_pc, head_bp_taken, head_bp_target, head_act_taken,
             head_act_target, error,
      input  ready
   );

   modport sink (
      input  valid, slot_out, occupancy, ready_out, value_out, head_op, head_dest,
             head_pc, head_bp_taken, head_bp_target, head_act_taken,
             head_act_target, error,
      output ready
   );
endinterface

// ===== rtl/core/rob_ctrl.sv =====
// ============================================================================
// rob_ctrl
// Request sequencer: accept, then execute once the response register is free.
// ============================================================================
module rob_ctrl
   import rob_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ctrl_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   ctrl_state_type state_ff;
   logic           out_valid_ff;
   logic           accept;
   logic           go;

   assign req_ready   = (state_ff == ST_IDLE);
   assign accept      = req_ready && req_valid;
   // execute when the response slot is empty or drains this cycle
   assign go          = (state_ff == ST_EXEC) && (!out_valid_ff || rsp_ready);
   assign cmd.capture = accept;
   assign cmd.execute = go;
   assign rsp_valid   = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (go) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (go) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== rtl/core/rob_dp.sv =====
// ============================================================================
// rob_dp
// Reorder buffer datapath: entry memory with per-entry valid bits,
// head/tail pointers, fill count and the response register.
// ============================================================================
module rob_dp
   import rob_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_cmd_type    cmd,
   input  req_payload_type req_in,
   output rsp_payload_type rsp_out,
   output dp_status_type   status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type            mem [DEPTH];
   logic [DEPTH-1:0]     valid_ff;
   logic [PTR_W-1:0]     head_ff;
   logic [PTR_W-1:0]     tail_ff;
   logic [CNT_W-1:0]     count_ff;
   req_payload_type      req_ff;
   entry_type            rd_head_ff;
   entry_type            rd_tag_ff;
   logic                 rd_head_vld_ff;
   logic                 rd_tag_vld_ff;
   rsp_payload_type      rsp_ff;

   logic [PTR_W-1:0]     rd_tag_idx;
   logic [PTR_W-1:0]     tag_idx;
   logic                 tag_ok;
   entry_type            eh;
   entry_type            et;
   rsp_payload_type      rsp_in;
   logic                 wr_en;
   logic [PTR_W-1:0]     wr_idx;
   entry_type            wr_data;
   logic                 clr_head;
   logic                 flush_all;
   logic [PTR_W-1:0]     head_in;
   logic [PTR_W-1:0]     tail_in;
   logic [CNT_W-1:0]     count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign rd_tag_idx = PTR_W'(req_in.tag);
   assign tag_idx    = PTR_W'(req_ff.tag);
   assign tag_ok     = (32'(req_ff.tag) < DEPTH);

   // never-written or cleared entries read as zero
   assign eh = rd_head_vld_ff ? rd_head_ff : '0;
   assign et = rd_tag_vld_ff  ? rd_tag_ff  : '0;

   always_comb begin
      rsp_in                  = '0;
      rsp_in.slot_out         = 4'(head_ff);
      rsp_in.ready_out        = eh.ready;
      rsp_in.value_out        = eh.value;
      rsp_in.head_op          = eh.op;
      rsp_in.head_dest        = eh.dest;
      rsp_in.head_pc          = eh.pc;
      rsp_in.head_bp_taken    = eh.bp_taken;
      rsp_in.head_bp_target   = eh.bp_target;
      rsp_in.head_act_taken   = eh.act_taken;
      rsp_in.head_act_target  = eh.act_target;
      rsp_in.error            = ERR_OK;
      wr_en     = 1'b0;
      wr_idx    = tag_idx;
      wr_data   = et;
      clr_head  = 1'b0;
      flush_all = 1'b0;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;

      unique case (cmd_type'(req_ff.cmd))
         CMD_ALLOC: begin
            rsp_in.slot_out = 4'(tail_ff);
            if (count_ff == CNT_W'(DEPTH)) begin
               rsp_in.error = ERR_FULL;
            end else begin
               wr_en        = 1'b1;
               wr_idx       = tail_ff;
               wr_data      = '0;
               wr_data.busy = 1'b1;
               wr_data.op   = req_ff.op_kind;
               wr_data.dest = req_ff.dest_index;
               wr_data.pc   = req_ff.instr_pc;
               tail_in      = next_ptr(tail_ff);
               count_in     = count_ff + 1'b1;
            end
         end
         CMD_WB: begin
            wr_en         = tag_ok;
            wr_data.value = req_ff.result_value;
            wr_data.ready = 1'b1;
         end
         CMD_SET_ACT: begin
            wr_en              = tag_ok;
            wr_data.act_taken  = req_ff.branch_taken;
            wr_data.act_target = req_ff.branch_target;
         end
         CMD_SET_PRED: begin
            wr_en             = tag_ok;
            wr_data.bp_taken  = req_ff.branch_taken;
            wr_data.bp_target = req_ff.branch_target;
         end
         CMD_COMMIT: begin
            if (count_ff == '0) begin
               rsp_in.error = ERR_EMPTY;
            end else begin
               clr_head = 1'b1;
               head_in  = next_ptr(head_ff);
               count_in = count_ff - 1'b1;
            end
         end
         CMD_FLUSH: begin
            flush_all = 1'b1;
            head_in   = tail_ff;
            count_in  = '0;
         end
         CMD_QUERY: begin
            rsp_in.ready_out = tag_ok ? et.ready : 1'b0;
            rsp_in.value_out = tag_ok ? et.value : '0;
         end
         default: ;
      endcase
      rsp_in.occupancy = 5'(count_in);
   end

   // entry memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_head_ff <= mem[head_ff];
         rd_tag_ff  <= mem[rd_tag_idx];
      end
      if (cmd.execute && wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_in;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         rd_head_vld_ff <= 1'b0;
         rd_tag_vld_ff  <= 1'b0;
      end else begin
         if (cmd.capture) begin
            rd_head_vld_ff <= valid_ff[head_ff];
            rd_tag_vld_ff  <= valid_ff[rd_tag_idx];
         end
         if (cmd.execute) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
            // at most one of these per command; query and unused codes touch none
            if (flush_all) begin
               valid_ff <= '0;
            end else if (wr_en) begin
               valid_ff[wr_idx] <= 1'b1;
            end else if (clr_head) begin
               valid_ff[head_ff] <= 1'b0;
            end
         end
      end
   end

   assign rsp_out      = rsp_ff;
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

// ===== rtl/core/reorder_buffer.sv =====
// ============================================================================
// reorder_buffer
// Circular reorder buffer, one command per request, one response each.
// ============================================================================
// Usage:
//   req_chan carries one command (allocate, writeback, set actual branch,
//   set prediction, commit, flush, query) with its operands. rsp_chan
//   returns one response per request: slot, occupancy after the command,
//   ready/value of the queried tag or the head, the head entry fields as
//   they stood before the command, and an error code (allocate while full
//   and commit while empty are dropped and flagged).
//   Capture registers a request and reads the entry memory; execute then
//   applies the command, writes back and loads the response register once
//   that is free. The next request is taken only after the current one
//   has executed.
//   The response register parts the channels: the next request is taken
//   while a response still waits. If the receiver stalls, one more request
//   is accepted and held until the response register drains; then
//   req_chan.ready stays low.
//   Reset (synchronous, active high) empties the buffer: pointers and
//   count go to zero, all entry valid bits clear at once, and no response
//   is pending. There is no clearing pass.
// ============================================================================
module reorder_buffer
   import rob_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   rob_req_if.sink   req_chan,
   rob_rsp_if.source rsp_chan
);

   ctrl_cmd_type    cmd;
   dp_status_type   status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;

   // pack request fields for the datapath
   assign req_payload.cmd           = req_chan.cmd;
   assign req_payload.tag           = req_chan.tag;
   assign req_payload.op_kind       = req_chan.op_kind;
   assign req_payload.dest_index    = req_chan.dest_index;
   assign req_payload.instr_pc      = req_chan.instr_pc;
   assign req_payload.result_value  = req_chan.result_value;
   assign req_payload.branch_taken  = req_chan.branch_taken;
   assign req_payload.branch_target = req_chan.branch_target;

   rob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   rob_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_in  (req_payload),
      .rsp_out (rsp_payload),
      .status  (status)
   );

   // unpack the response register
   assign rsp_chan.slot_out         = rsp_payload.slot_out;
   assign rsp_chan.occupancy        = rsp_payload.occupancy;
   assign rsp_chan.ready_out        = rsp_payload.ready_out;
   assign rsp_chan.value_out        = rsp_payload.value_out;
   assign rsp_chan.head_op          = rsp_payload.head_op;
   assign rsp_chan.head_dest        = rsp_payload.head_dest;
   assign rsp_chan.head_pc          = rsp_payload.head_pc;
   assign rsp_chan.head_bp_taken    = rsp_payload.head_bp_taken;
   assign rsp_chan.head_bp_target   = rsp_payload.head_bp_target;
   assign rsp_chan.head_act_taken   = rsp_payload.head_act_taken;
   assign rsp_chan.head_act_target  = rsp_payload.head_act_target;
   assign rsp_chan.error            = rsp_payload.error;

   // a request in flight blocks the next one: ready is low in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request accepted while one is executing");

   // full and empty never together
   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      !(status.full && status.empty))
      else $error("buffer flagged full and empty");

   // a dropped allocate leaves the buffer full
   a_full_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.error == ERR_FULL) |->
         (rsp_chan.occupancy == 5'(DEPTH)))
      else $error("allocate flagged full but buffer not full");

   // a dropped commit leaves the buffer empty
   a_empty_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.error == ERR_EMPTY) |->
         (rsp_chan.occupancy == 5'd0))
      else $error("commit flagged empty but buffer not empty");

endmodule
